FILE: hdl/uart_xon_xoff_flow_control_unit_macros.svh
`ifndef UART_XON_XOFF_FLOW_CONTROL_UNIT_MACROS_SVH
`define UART_XON_XOFF_FLOW_CONTROL_UNIT_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define UXF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("uxf assertion failed");

// next-cycle implication
`define UXF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("uxf assertion failed");

`endif

FILE: hdl/uxf_pkg.sv
package uxf_pkg;

    localparam logic [7:0] CH_XON  = 8'h11;
    localparam logic [7:0] CH_XOFF = 8'h13;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;

    typedef enum logic [1:0] {
        OP_TX_FREE = 2'd0,
        OP_RX_BYTE = 2'd1,
        OP_READY   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        CFG_XON_ENABLE        = 2'd0,
        CFG_CONSOLE_MODE      = 2'd1,
        CFG_NEWLINE_TRANSLATE = 2'd2,
        CFG_CHANNEL_PRESENT   = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        DEST_CONSOLE = 1'b0,
        DEST_CHANNEL = 1'b1
    } t_dest;

    typedef struct packed {
        t_op        op;
        logic [7:0] rx_byte;
        logic       console_has_byte;
        logic [7:0] console_byte;
        logic       channel_has_byte;
        logic [7:0] channel_byte;
        logic       console_accepts;
        logic       channel_accepts;
    } t_in_item;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       took_console;
        logic       took_channel;
        logic       deliver_valid;
        logic [7:0] deliver_byte;
        t_dest      deliver_to;
        logic       output_held;
    } t_out_item;

    typedef struct packed {
        t_cfg_idx addr;
        logic     wdata;
    } t_cfg_req;

    typedef struct packed {
        logic xon_due;
        logic lf_due;
        logic busy;
        logic xoff_issued;
        logic xoff_due;
        logic held;
    } t_flags;

endpackage

FILE: hdl/uxf_in_if.sv
interface uxf_in_if import uxf_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/uxf_out_if.sv
interface uxf_out_if import uxf_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/uxf_cfg_if.sv
interface uxf_cfg_if import uxf_pkg::*;;
    logic     valid;
    logic     ready;
    t_cfg_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/uart_xon_xoff_flow_control_unit.sv
// an accepted request waits in the input register until the result register is empty or read
// throughput: one request per unstalled cycle, set by the single flag update between registers
// the input register refills while a stalled result waits, so one request can queue behind it
// reset (synchronous, active low) clears configuration, flow flags and both valid bits
// configuration writes are always ready and take effect at once
module uart_xon_xoff_flow_control_unit import uxf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    uxf_in_if.sink    i_in,
    uxf_out_if.source o_out,
    uxf_cfg_if.sink   i_cfg
);

`include "uart_xon_xoff_flow_control_unit_macros.svh"

    logic      r_xon_enable;
    logic      r_console_mode;
    logic      r_newline_translate;
    logic      r_channel_present;
    t_flags    r_flags;
    t_flags    n_flags;
    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      r_out_valid;
    logic      advance;
    logic      in_take;

    assign advance   = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_take   = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xon_enable        <= 1'b0;
            r_console_mode      <= 1'b0;
            r_newline_translate <= 1'b0;
            r_channel_present   <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.addr)
                CFG_XON_ENABLE:        r_xon_enable        <= i_cfg.data.wdata;
                CFG_CONSOLE_MODE:      r_console_mode      <= i_cfg.data.wdata;
                CFG_NEWLINE_TRANSLATE: r_newline_translate <= i_cfg.data.wdata;
                CFG_CHANNEL_PRESENT:   r_channel_present   <= i_cfg.data.wdata;
                default: ;
            endcase
        end
    end

    // event decode and transmit selection
    always_comb begin
        logic       want_tx;
        logic       picked;
        logic [7:0] rx_c;
        logic [7:0] tx_b;
        n_flags = r_flags;
        n_out   = '0;
        want_tx = 1'b0;
        picked  = 1'b0;
        rx_c    = r_in.rx_byte;
        tx_b    = '0;
        case (r_in.op)
            OP_TX_FREE: begin
                want_tx = 1'b1;
            end
            OP_RX_BYTE: begin
                if (rx_c == CH_XOFF) begin
                    if (r_xon_enable) n_flags.held = 1'b1;
                end else if (rx_c == CH_XON) begin
                    if (r_xon_enable) begin
                        n_flags.held = 1'b0;
                        want_tx = !r_flags.busy;
                    end
                end else begin
                    if (r_newline_translate && rx_c == CH_CR) rx_c = CH_LF;
                    if (r_console_mode && r_in.console_accepts) begin
                        n_out.deliver_valid = 1'b1;
                        n_out.deliver_byte  = rx_c;
                        n_out.deliver_to    = DEST_CONSOLE;
                    end else if (r_channel_present && r_in.channel_accepts) begin
                        n_out.deliver_valid = 1'b1;
                        n_out.deliver_byte  = rx_c;
                        n_out.deliver_to    = DEST_CHANNEL;
                    end else if (r_xon_enable) begin
                        n_flags.xoff_due = 1'b1;
                        want_tx = !r_flags.busy;
                    end
                end
            end
            OP_READY: begin
                if (r_xon_enable && r_flags.xoff_issued) begin
                    n_flags.xon_due = 1'b1;
                    want_tx = !r_flags.busy;
                end
            end
            default: ;
        endcase
        if (want_tx) begin
            if (n_flags.held) begin
                n_flags.busy = 1'b0;
            end else begin
                picked = 1'b1;
                if (n_flags.xoff_due) begin
                    tx_b = CH_XOFF;
                    n_flags.xoff_due    = 1'b0;
                    n_flags.xoff_issued = 1'b1;
                end else if (n_flags.xon_due) begin
                    tx_b = CH_XON;
                    n_flags.xon_due     = 1'b0;
                    n_flags.xoff_issued = 1'b0;
                end else if (n_flags.lf_due) begin
                    tx_b = CH_LF;
                    n_flags.lf_due = 1'b0;
                end else if (r_console_mode && r_in.console_has_byte) begin
                    tx_b = r_in.console_byte;
                    n_out.took_console = 1'b1;
                end else if (r_channel_present && r_in.channel_has_byte) begin
                    tx_b = r_in.channel_byte;
                    n_out.took_channel = 1'b1;
                end else begin
                    picked = 1'b0;
                end
                if (!picked) begin
                    n_flags.busy = 1'b0;
                end else begin
                    if ((n_out.took_console || n_out.took_channel) && r_newline_translate
                            && tx_b == CH_LF) begin
                        n_flags.lf_due = 1'b1;
                        tx_b = CH_CR;
                    end
                    n_flags.busy   = 1'b1;
                    n_out.tx_valid = 1'b1;
                    n_out.tx_byte  = tx_b;
                end
            end
        end
        n_out.output_held = n_flags.held;
    end

    // input register, result register and flow flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_flags     <= n_flags;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) r_in <= i_in.data;
        if (advance) r_out <= n_out;
    end

    `UXF_ASSERT_IMP(a_tx_xor_deliver, o_out.valid, !(o_out.data.tx_valid && o_out.data.deliver_valid))
    `UXF_ASSERT_IMP(a_one_source, o_out.valid, !(o_out.data.took_console && o_out.data.took_channel))
    `UXF_ASSERT_NEXT(a_busy_after_tx, advance && n_out.tx_valid, r_flags.busy)
    `UXF_ASSERT_IMP(a_held_blocks_tx, advance && r_flags.held && r_in.op != OP_RX_BYTE, !n_out.tx_valid)

endmodule

FILE: verif/uart_xon_xoff_flow_control_unit_tb.sv
module uart_xon_xoff_flow_control_unit_tb;
    import uxf_pkg::*;

    class flow_scoreboard;
        logic      xon_enable;
        logic      console_mode;
        logic      newline_translate;
        logic      channel_present;
        t_flags    fl;
        t_out_item due_results[$];
        int        n_errors;

        function new();
            xon_enable        = 1'b0;
            console_mode      = 1'b0;
            newline_translate = 1'b0;
            channel_present   = 1'b0;
            fl                = '0;
            n_errors          = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic v);
            case (idx)
                CFG_XON_ENABLE:        xon_enable = v;
                CFG_CONSOLE_MODE:      console_mode = v;
                CFG_NEWLINE_TRANSLATE: newline_translate = v;
                CFG_CHANNEL_PRESENT:   channel_present = v;
                default: ;
            endcase
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // one transmit attempt, priority xoff, xon, lf, console, channel
        function void try_send(t_in_item it, inout t_out_item r);
            logic [7:0] b;
            if (fl.held) begin
                fl.busy = 1'b0;
                return;
            end
            if (fl.xoff_due) begin
                b = CH_XOFF;
                fl.xoff_due = 1'b0;
                fl.xoff_issued = 1'b1;
            end else if (fl.xon_due) begin
                b = CH_XON;
                fl.xon_due = 1'b0;
                fl.xoff_issued = 1'b0;
            end else if (fl.lf_due) begin
                b = CH_LF;
                fl.lf_due = 1'b0;
            end else if (console_mode && it.console_has_byte) begin
                b = it.console_byte;
                r.took_console = 1'b1;
            end else if (channel_present && it.channel_has_byte) begin
                b = it.channel_byte;
                r.took_channel = 1'b1;
            end else begin
                fl.busy = 1'b0;
                return;
            end
            if ((r.took_console || r.took_channel) && newline_translate && b == CH_LF) begin
                fl.lf_due = 1'b1;
                b = CH_CR;
            end
            fl.busy = 1'b1;
            r.tx_valid = 1'b1;
            r.tx_byte = b;
        endfunction

        function void note_request(t_in_item it);
            t_out_item  r;
            logic [7:0] c;
            r = '0;
            case (it.op)
                OP_TX_FREE: try_send(it, r);
                OP_RX_BYTE: begin
                    c = it.rx_byte;
                    if (c == CH_XOFF) begin
                        if (xon_enable) fl.held = 1'b1;
                    end else if (c == CH_XON) begin
                        if (xon_enable) begin
                            fl.held = 1'b0;
                            if (!fl.busy) try_send(it, r);
                        end
                    end else begin
                        if (newline_translate && c == CH_CR) c = CH_LF;
                        if (console_mode && it.console_accepts) begin
                            r.deliver_valid = 1'b1;
                            r.deliver_byte = c;
                            r.deliver_to = DEST_CONSOLE;
                        end else if (channel_present && it.channel_accepts) begin
                            r.deliver_valid = 1'b1;
                            r.deliver_byte = c;
                            r.deliver_to = DEST_CHANNEL;
                        end else if (xon_enable) begin
                            fl.xoff_due = 1'b1;
                            if (!fl.busy) try_send(it, r);
                        end
                    end
                end
                OP_READY: begin
                    if (xon_enable && fl.xoff_issued) begin
                        fl.xon_due = 1'b1;
                        if (!fl.busy) try_send(it, r);
                    end
                end
                default: ;
            endcase
            r.output_held = fl.held;
            due_results.push_back(r);
        endfunction

        function void report(string what, logic [7:0] e, logic [7:0] a);
            n_errors++;
            $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, what, e, a);
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp_r;
            if (due_results.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                return;
            end
            exp_r = due_results.pop_front();
            if (got.tx_valid !== exp_r.tx_valid)
                report("tx_valid", 8'(exp_r.tx_valid), 8'(got.tx_valid));
            if (got.tx_byte !== exp_r.tx_byte)
                report("tx_byte", exp_r.tx_byte, got.tx_byte);
            if (got.took_console !== exp_r.took_console)
                report("took_console", 8'(exp_r.took_console), 8'(got.took_console));
            if (got.took_channel !== exp_r.took_channel)
                report("took_channel", 8'(exp_r.took_channel), 8'(got.took_channel));
            if (got.deliver_valid !== exp_r.deliver_valid)
                report("deliver_valid", 8'(exp_r.deliver_valid), 8'(got.deliver_valid));
            if (got.deliver_byte !== exp_r.deliver_byte)
                report("deliver_byte", exp_r.deliver_byte, got.deliver_byte);
            if (got.deliver_to !== exp_r.deliver_to)
                report("deliver_to", 8'(exp_r.deliver_to), 8'(got.deliver_to));
            if (got.output_held !== exp_r.output_held)
                report("output_held", 8'(exp_r.output_held), 8'(got.output_held));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   send_idle;
    int   stall_pct;

    flow_scoreboard sb = new();

    uxf_in_if  in_if ();
    uxf_out_if out_if ();
    uxf_cfg_if cfg_if ();

    uart_xon_xoff_flow_control_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1)
            sb.check_result(out_if.data);
    end

    function automatic t_in_item mk(t_op op, logic [7:0] rx, logic ch, logic [7:0] cb,
                                    logic nh, logic [7:0] nb, logic ca, logic na);
        t_in_item it;
        it.op = op;
        it.rx_byte = rx;
        it.console_has_byte = ch;
        it.console_byte = cb;
        it.channel_has_byte = nh;
        it.channel_byte = nb;
        it.console_accepts = ca;
        it.channel_accepts = na;
        return it;
    endfunction

    function automatic logic [7:0] pick_rx();
        if ($urandom_range(99) < 45) begin
            case ($urandom_range(3))
                0: return CH_XON;
                1: return CH_XOFF;
                2: return CH_CR;
                default: return CH_LF;
            endcase
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_src();
        if ($urandom_range(99) < 30) return CH_LF;
        return 8'($urandom_range(255));
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        int       r;
        r = $urandom_range(99);
        if (r < 40) it.op = OP_TX_FREE;
        else if (r < 75) it.op = OP_RX_BYTE;
        else if (r < 95) it.op = OP_READY;
        else it.op = t_op'(2'd3);
        it.rx_byte = pick_rx();
        it.console_has_byte = 1'($urandom_range(1));
        it.console_byte = pick_src();
        it.channel_has_byte = 1'($urandom_range(1));
        it.channel_byte = pick_src();
        it.console_accepts = 1'($urandom_range(1));
        it.channel_accepts = 1'($urandom_range(1));
        return it;
    endfunction

    task automatic send_item(t_in_item it);
        in_if.valid <= 1'b1;
        in_if.data <= it;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_request(it);
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_if.valid <= 1'b0;
        while (sb.pending() > 0 && guard < 50000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_config(input logic xe, input logic cm, input logic nt,
                                input logic cp);
        logic [3:0] v;
        t_cfg_req   req;
        v = {cp, nt, cm, xe};
        for (int i = 0; i < 4; i++) begin
            req.addr = t_cfg_idx'(i);
            req.wdata = v[i];
            cfg_if.valid <= 1'b1;
            cfg_if.data <= req;
            do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
            sb.set_reg(req.addr, req.wdata);
        end
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        int sched_send[4];
        int sched_stall[4];
        sched_send  = '{0, 67, 0, 31};
        sched_stall = '{0, 0, 67, 31};
        send_idle = 0;
        stall_pct = 0;
        i_rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.data <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration, everything is ignored or dropped
        send_item(mk(OP_TX_FREE, 8'h00, 1'b1, 8'h55, 1'b1, 8'hAA, 1'b0, 1'b0));
        send_item(mk(OP_RX_BYTE, 8'hFF, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1));
        send_item(mk(OP_RX_BYTE, CH_XOFF, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0));
        send_item(mk(OP_READY, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0));
        drain();

        apply_config(1'b1, 1'b1, 1'b1, 1'b1);
        send_item(mk(OP_RX_BYTE, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0));
        send_item(mk(OP_RX_BYTE, CH_CR, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1));
        // no sink, xoff goes out at once
        send_item(mk(OP_RX_BYTE, 8'hFF, 1'b1, 8'h5A, 1'b0, 8'h00, 1'b0, 1'b0));
        send_item(mk(OP_READY, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0));
        send_item(mk(OP_TX_FREE, 8'h00, 1'b1, CH_LF, 1'b1, 8'h77, 1'b0, 1'b0));
        send_item(mk(OP_TX_FREE, 8'h00, 1'b1, CH_LF, 1'b1, 8'h77, 1'b0, 1'b0));
        send_item(mk(OP_TX_FREE, 8'h00, 1'b1, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0));
        send_item(mk(OP_TX_FREE, 8'h00, 1'b0, 8'h00, 1'b1, 8'hFF, 1'b0, 1'b0));
        send_item(mk(OP_TX_FREE, 8'h00, 1'b0, 8'h00, 1'b1, CH_LF, 1'b0, 1'b0));
        send_item(mk(OP_TX_FREE, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0));
        send_item(mk(OP_TX_FREE, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0));
        send_item(mk(OP_RX_BYTE, CH_XOFF, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1));
        send_item(mk(OP_TX_FREE, 8'h00, 1'b1, 8'h42, 1'b1, 8'h24, 1'b0, 1'b0));
        send_item(mk(OP_READY, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0));
        send_item(mk(OP_RX_BYTE, CH_XON, 1'b1, 8'h42, 1'b0, 8'h00, 1'b1, 1'b1));
        send_item(mk(t_op'(2'd3), 8'hFF, 1'b1, 8'hFF, 1'b1, 8'hFF, 1'b1, 1'b1));
        send_item(mk(OP_RX_BYTE, CH_LF, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1));
        drain();

        for (int blk = 0; blk < 8; blk++) begin
            if (blk == 0)
                apply_config(1'b1, 1'b1, 1'b1, 1'b1);
            else if (blk == 1)
                apply_config(1'b0, 1'b0, 1'b0, 1'b0);
            else
                apply_config(1'($urandom_range(3) != 0), 1'($urandom_range(1)),
                             1'($urandom_range(1)), 1'($urandom_range(1)));
            send_idle = sched_send[blk % 4];
            stall_pct <= sched_stall[blk % 4];
            for (int n = 0; n < 56; n++)
                send_item(rand_item());
            drain();
        end

        stall_pct <= 0;
        drain();
        if (sb.pending() != 0) begin
            sb.n_errors++;
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
        end
        if (sb.n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
